>>> src/wfms_pkg.sv
// ----------------------------------------------------------------------------
// wfms_pkg: shared types, codes and constant tables
// Payload structs, sequencer states, register indexes and the window and
// twiddle tables, which are computed once at elaboration.
// ----------------------------------------------------------------------------
package wfms_pkg;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] magnitude;
    logic        no_data;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_LOG2 = 2'd0,
    CFG_WINDOW_KIND = 2'd1,
    CFG_REMOVE_MEAN = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    WIN_RECT    = 2'd0,
    WIN_HANN    = 2'd1,
    WIN_HAMMING = 2'd2
  } win_kind_t;

  localparam logic REQ_PUSH    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MEAN_RD,
    S_MEAN_ACC,
    S_MEAN_END,
    S_LD_RD,
    S_LD_MUL,
    S_LD_WR,
    S_BF_RD,
    S_BF_LAT,
    S_BF_M0,
    S_BF_M1,
    S_BF_M2,
    S_BF_M3,
    S_BF_TI,
    S_BF_WA,
    S_BF_WB,
    S_MG_RD,
    S_MG_M0,
    S_MG_M1,
    S_MG_SQI,
    S_MG_SQ,
    S_MG_OUT
  } fsm_state_t;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint PI_HALF_Q30 = 64'sd1686629713;
  localparam longint HAMMING_A   = 64'sd579820585;
  localparam longint HAMMING_B   = 64'sd493921239;
  localparam longint CK [5] = '{64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};
  localparam longint SK [5] = '{64'sd110, 64'sd72, 64'sd42, 64'sd20, 64'sd6};

  localparam logic [16:0] W_ONE = 17'd32768;

  typedef logic [16:0]        win_tab_t [256];
  typedef logic signed [31:0] tw_tab_t  [64];

  // Denominator codes 0 to 4 are N - 1 for the symmetric window lengths 8 .. 128,
  // any other code is the twiddle circle of 128 points.
  function automatic longint div_den(longint v, int sel);
    longint res;
    case (sel)
      0:       res = v / 7;
      1:       res = v / 15;
      2:       res = v / 31;
      3:       res = v / 63;
      4:       res = v / 127;
      default: res = v / 128;
    endcase
    return res;
  endfunction

  // Q30 cosine and sine of 2*pi*num/den, packed as {cos, sin}.
  function automatic logic [63:0] trig_cs(int num, int sel);
    longint den, m, nn, q, r, x, x2, cx, t, sx, c, s;
    int     i;
    case (sel)
      0:       den = 7;
      1:       den = 15;
      2:       den = 31;
      3:       den = 63;
      4:       den = 127;
      default: den = 128;
    endcase
    m = longint'(num);
    if (m >= den) m = m - den;
    nn = m * 4;
    q  = div_den(nn, sel);
    r  = nn - q * den;
    x  = div_den(r * PI_HALF_Q30, sel);
    x2 = x * x / Q30_ONE;
    cx = Q30_ONE;
    t  = Q30_ONE;
    for (i = 0; i < 5; i++) begin
      cx = Q30_ONE - (x2 * cx / Q30_ONE) / CK[i];
      t  = Q30_ONE - (x2 * t / Q30_ONE) / SK[i];
    end
    sx = x * t / Q30_ONE;
    case (q % 4)
      0:       begin c = cx;  s = sx;  end
      1:       begin c = -sx; s = cx;  end
      2:       begin c = -cx; s = -sx; end
      default: begin c = sx;  s = -cx; end
    endcase
    return {c[31:0], s[31:0]};
  endfunction

  // Window weights for the power-of-two lengths 8 .. 128, entry (n - 8) + i.
  function automatic win_tab_t build_win(int kind);
    win_tab_t    tab;
    logic [63:0] cs;
    longint      c, wq;
    int          k, i;
    for (i = 0; i < 256; i++) tab[i] = 17'd0;
    for (k = 3; k <= 7; k++) begin
      for (i = 0; i < (1 << k); i++) begin
        cs = trig_cs(i, k - 3);
        c  = longint'($signed(cs[63:32]));
        if (kind == 1) wq = (Q30_ONE - c) / 2;
        else           wq = HAMMING_A - HAMMING_B * c / Q30_ONE;
        if (wq < 0)       wq = 0;
        if (wq > Q30_ONE) wq = Q30_ONE;
        wq = (wq + 16384) >>> 15;
        tab[(1 << k) - 8 + i] = wq[16:0];
      end
    end
    return tab;
  endfunction

  // Twiddles on a circle of 128 points, first half turn.
  function automatic tw_tab_t build_tw(int part);
    tw_tab_t     tab;
    logic [63:0] cs;
    int          i;
    for (i = 0; i < 64; i++) begin
      cs = trig_cs(i, 5);
      tab[i] = (part == 0) ? cs[63:32] : cs[31:0];
    end
    return tab;
  endfunction

  localparam win_tab_t WIN_HANN_TAB    = build_win(1);
  localparam win_tab_t WIN_HAMMING_TAB = build_win(2);
  localparam tw_tab_t  TW_COS          = build_tw(0);
  localparam tw_tab_t  TW_SIN          = build_tw(1);

endpackage

>>> src/windowed_fft_magnitude_spectrum.sv
// ----------------------------------------------------------------------------
// windowed_fft_magnitude_spectrum: sliding-window magnitude spectrum
// Keeps the latest samples in a circular store; on a compute request it
// windows the last N samples, runs an in-place radix-2 FFT and streams the
// magnitudes of bins 1 .. N/2-1.
//
//   channel  ports                        transfer
//   input    start, busy, in_data         start high and busy low at a clock
//   result   out_strobe, out_data         out_strobe high, one cycle per item
//   config   cfg_we, cfg_index, cfg_wdata cfg_we high at a clock
//
// A push leaves busy low, so while no compute runs pushes can come every cycle.
// A short-window compute answers in the next cycle without raising busy.
// A full compute holds busy through the optional mean pass, the window load,
// the butterflies (through one shared multiplier) and a bit-serial square root
// per bin on squares of PW = 2 * DW bits, DW = SAMPLE_BITS + 8.
// Reset is synchronous; the stores are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module windowed_fft_magnitude_spectrum
  import wfms_pkg::*;
#(
  parameter int MAX_POINTS  = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_strobe,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_wdata
);

  localparam int FLOG = $clog2(MAX_POINTS + 1) - 1;
  localparam int KMAX = (FLOG > 7) ? 7 : FLOG;
  localparam int NMAX = 1 << KMAX;
  localparam int AW   = KMAX;
  localparam int SAW  = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int DW   = SAMPLE_BITS + 8;
  localparam int PW   = 2 * DW;
  localparam int SUMW = SAMPLE_BITS + KMAX + 1;

  fsm_state_t state_r, state_nxt;

  logic [2:0] log2_r;
  logic [1:0] kind_r;
  logic       rmean_r;

  logic [SAW-1:0] wp_r;
  logic [CW-1:0]  cnt_st_r;
  logic [SAW-1:0] rptr_r;
  logic signed [SAMPLE_BITS-1:0] sdat_r;

  logic [KMAX:0] idx_r;
  logic [2:0]    stage_r;
  logic signed [SUMW-1:0]        sum_r;
  logic signed [SAMPLE_BITS-1:0] mean_r;
  logic [16:0] w_r;
  logic signed [63:0] prod_r, acc_r;
  logic signed [31:0] c_r, s_r;
  logic [PW-1:0] a_r, b_r, rda_r, rdb_r;
  logic signed [DW-1:0] tr_r, ti_r;
  logic [PW-1:0] sq_v_r, sq_res_r, sq_bit_r;
  logic      out_strobe_r;
  out_item_t out_data_r;

  logic signed [SAMPLE_BITS-1:0] sstore [MAX_POINTS];
  logic [PW-1:0]                 wbuf   [NMAX];

  // Effective window length.
  logic [2:0]    k_eff;
  logic [KMAX:0] n_w;
  always_comb begin
    if (log2_r < 3'd3)                k_eff = 3'd3;
    else if (log2_r > 3'(KMAX))       k_eff = 3'(KMAX);
    else                              k_eff = log2_r;
    n_w = (KMAX + 1)'(1) << k_eff;
  end

  logic [KMAX:0] half_n, last_bin;
  assign half_n   = n_w >> 1;
  assign last_bin = half_n - (KMAX + 1)'(1);

  logic enough, push_go, comp_go;
  assign enough  = (CW + 1)'(cnt_st_r) >= (CW + 1)'(n_w);
  assign push_go = start && !busy && (in_data.req_type == REQ_PUSH);
  assign comp_go = start && !busy && (in_data.req_type == REQ_COMPUTE);

  logic [SAW:0] wp_ext, n_ext, base_ext;
  logic [SAW-1:0] base, rptr_inc;
  always_comb begin
    wp_ext = (SAW + 1)'(wp_r);
    n_ext  = (SAW + 1)'(n_w);
    if (wp_ext >= n_ext) base_ext = wp_ext - n_ext;
    else                 base_ext = wp_ext + (SAW + 1)'(MAX_POINTS) - n_ext;
    base     = base_ext[SAW-1:0];
    rptr_inc = (rptr_r == SAW'(MAX_POINTS - 1)) ? '0 : rptr_r + SAW'(1);
  end

  logic [SAW-1:0] wp_inc;
  assign wp_inc = (wp_r == SAW'(MAX_POINTS - 1)) ? '0 : wp_r + SAW'(1);

  logic [31:0] raw_sample;
  assign raw_sample = {16'd0, in_data.sample};

  // Bit-reversed load address and the butterfly pair of the current stage.
  logic [AW-1:0] rev_full, rev_addr, bf_b, bf_half, bf_mask, bf_i, bf_p;
  logic [6:0]    tw_sh;
  logic [5:0]    tw_idx;
  always_comb begin
    for (int b = 0; b < AW; b++) rev_full[b] = idx_r[AW-1-b];
    rev_addr = rev_full >> (3'(KMAX) - k_eff);
    bf_b     = idx_r[AW-1:0];
    bf_half  = AW'(1) << (stage_r - 3'd1);
    bf_mask  = bf_half - AW'(1);
    bf_i     = ((bf_b & ~bf_mask) << 1) | (bf_b & bf_mask);
    bf_p     = bf_i | bf_half;
    tw_sh    = 7'(bf_b & bf_mask) << (3'd7 - stage_r);
    tw_idx   = tw_sh[5:0];
  end

  logic [7:0] win_idx;
  logic [16:0] w_sel;
  always_comb begin
    win_idx = 8'(n_w) - 8'd8 + 8'(idx_r);
    case (kind_r)
      WIN_HANN:    w_sel = WIN_HANN_TAB[win_idx];
      WIN_HAMMING: w_sel = WIN_HAMMING_TAB[win_idx];
      default:     w_sel = W_ONE;
    endcase
  end

  // Arithmetic helpers around the shared multiplier.
  logic signed [SAMPLE_BITS:0] d_val;
  logic signed [DW-1:0] ar, ai, br, bi, rre, rim;
  logic signed [63:0] ld_rnd, tr_rnd, ti_rnd;
  assign d_val  = (SAMPLE_BITS + 1)'(sdat_r) - (SAMPLE_BITS + 1)'(mean_r);
  assign ar     = a_r[PW-1:DW];
  assign ai     = a_r[DW-1:0];
  assign br     = b_r[PW-1:DW];
  assign bi     = b_r[DW-1:0];
  assign rre    = rda_r[PW-1:DW];
  assign rim    = rda_r[DW-1:0];
  assign ld_rnd = (prod_r + 64'sd16384) >>> 15;
  assign tr_rnd = (acc_r + prod_r + 64'sd536870912) >>> 30;
  assign ti_rnd = (acc_r - prod_r + 64'sd536870912) >>> 30;

  logic signed [SUMW-1:0] mean_full;
  assign mean_full = (sum_r + signed'(SUMW'(half_n))) >>> k_eff;

  logic [PW-1:0] sq_trial;
  logic          sq_take;
  assign sq_trial = sq_res_r + sq_bit_r;
  assign sq_take  = sq_v_r >= sq_trial;

  logic [PW:0] mag_sum, mag_sh;
  logic [15:0] mag_sat;
  always_comb begin
    mag_sum = {1'b0, sq_res_r} + (PW + 1)'(half_n);
    mag_sh  = mag_sum >> k_eff;
    mag_sat = (mag_sh > (PW + 1)'(65535)) ? 16'hFFFF : mag_sh[15:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (comp_go && enough) state_nxt = rmean_r ? S_MEAN_RD : S_LD_RD;
      S_MEAN_RD:  state_nxt = S_MEAN_ACC;
      S_MEAN_ACC: state_nxt = (idx_r == n_w - (KMAX + 1)'(1)) ? S_MEAN_END : S_MEAN_RD;
      S_MEAN_END: state_nxt = S_LD_RD;
      S_LD_RD:    state_nxt = S_LD_MUL;
      S_LD_MUL:   state_nxt = S_LD_WR;
      S_LD_WR:    state_nxt = (idx_r == n_w - (KMAX + 1)'(1)) ? S_BF_RD : S_LD_RD;
      S_BF_RD:    state_nxt = S_BF_LAT;
      S_BF_LAT:   state_nxt = S_BF_M0;
      S_BF_M0:    state_nxt = S_BF_M1;
      S_BF_M1:    state_nxt = S_BF_M2;
      S_BF_M2:    state_nxt = S_BF_M3;
      S_BF_M3:    state_nxt = S_BF_TI;
      S_BF_TI:    state_nxt = S_BF_WA;
      S_BF_WA:    state_nxt = S_BF_WB;
      S_BF_WB: begin
        if (idx_r == last_bin && stage_r == k_eff) state_nxt = S_MG_RD;
        else                                       state_nxt = S_BF_RD;
      end
      S_MG_RD:    state_nxt = S_MG_M0;
      S_MG_M0:    state_nxt = S_MG_M1;
      S_MG_M1:    state_nxt = S_MG_SQI;
      S_MG_SQI:   state_nxt = S_MG_SQ;
      S_MG_SQ:    if (sq_bit_r == '0) state_nxt = S_MG_OUT;
      S_MG_OUT:   state_nxt = (idx_r == last_bin) ? S_IDLE : S_MG_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Multiplier operands and work buffer ports.
  logic signed [31:0] mul_a, mul_b;
  logic [AW-1:0] wa_addr, wb_addr, wr_addr;
  logic          wr_en;
  logic [PW-1:0] wr_data;
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    wa_addr = bf_i;
    wb_addr = bf_p;
    wr_en   = 1'b0;
    wr_addr = bf_i;
    wr_data = {ar + tr_r, ai + ti_r};
    unique case (state_r)
      S_LD_MUL: begin
        mul_a = 32'(d_val);
        mul_b = signed'(32'(w_r));
      end
      S_LD_WR: begin
        wr_en   = 1'b1;
        wr_addr = rev_addr;
        wr_data = {ld_rnd[DW-1:0], DW'(0)};
      end
      S_BF_M0: begin mul_a = 32'(br); mul_b = c_r; end
      S_BF_M1: begin mul_a = 32'(bi); mul_b = s_r; end
      S_BF_M2: begin mul_a = 32'(bi); mul_b = c_r; end
      S_BF_M3: begin mul_a = 32'(br); mul_b = s_r; end
      S_BF_WA: wr_en = 1'b1;
      S_BF_WB: begin
        wr_en   = 1'b1;
        wr_addr = bf_p;
        wr_data = {ar - tr_r, ai - ti_r};
      end
      S_MG_RD, S_MG_M0, S_MG_M1: begin
        wa_addr = idx_r[AW-1:0];
        mul_a   = 32'(rre);
        mul_b   = (state_r == S_MG_M1) ? 32'(rim) : 32'(rre);
        if (state_r == S_MG_M1) mul_a = 32'(rim);
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Stores: no reset, registered reads.
  always_ff @(posedge clk) begin
    if (push_go) sstore[wp_r] <= SAMPLE_BITS'(raw_sample[SAMPLE_BITS-1:0]);
    sdat_r <= sstore[rptr_r];
    if (wr_en) wbuf[wr_addr] <= wr_data;
    rda_r <= wbuf[wa_addr];
    rdb_r <= wbuf[wb_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      log2_r       <= 3'd7;
      kind_r       <= WIN_RECT;
      rmean_r      <= 1'b0;
      wp_r         <= '0;
      cnt_st_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_LOG2: log2_r  <= cfg_wdata;
          CFG_WINDOW_KIND: kind_r  <= cfg_wdata[1:0];
          CFG_REMOVE_MEAN: rmean_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (push_go) begin
        wp_r <= wp_inc;
        if (cnt_st_r != CW'(MAX_POINTS)) cnt_st_r <= cnt_st_r + CW'(1);
      end
      if (comp_go && !enough) out_strobe_r <= 1'b1;
      if (state_r == S_MG_OUT) out_strobe_r <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        rptr_r  <= base;
        idx_r   <= '0;
        sum_r   <= '0;
        mean_r  <= '0;
        stage_r <= 3'd1;
        out_data_r <= '{bin_index: 6'd0, magnitude: 16'd0, no_data: 1'b1, last: 1'b1};
      end
      S_MEAN_ACC: begin
        sum_r  <= sum_r + SUMW'(sdat_r);
        idx_r  <= idx_r + (KMAX + 1)'(1);
        rptr_r <= rptr_inc;
      end
      S_MEAN_END: begin
        mean_r <= mean_full[SAMPLE_BITS-1:0];
        rptr_r <= base;
        idx_r  <= '0;
      end
      S_LD_RD: w_r <= w_sel;
      S_LD_WR: begin
        rptr_r <= rptr_inc;
        idx_r  <= (idx_r == n_w - (KMAX + 1)'(1)) ? '0 : idx_r + (KMAX + 1)'(1);
      end
      S_BF_LAT: begin
        a_r <= rda_r;
        b_r <= rdb_r;
        c_r <= TW_COS[tw_idx];
        s_r <= TW_SIN[tw_idx];
      end
      S_BF_M1: acc_r <= prod_r;
      S_BF_M2: tr_r  <= tr_rnd[DW-1:0];
      S_BF_M3: acc_r <= prod_r;
      S_BF_TI: ti_r  <= ti_rnd[DW-1:0];
      S_BF_WB: begin
        if (idx_r == last_bin) begin
          stage_r <= stage_r + 3'd1;
          idx_r   <= (stage_r == k_eff) ? (KMAX + 1)'(1) : '0;
        end else begin
          idx_r <= idx_r + (KMAX + 1)'(1);
        end
      end
      S_MG_M1: acc_r <= prod_r;
      S_MG_SQI: begin
        sq_v_r   <= PW'(acc_r) + PW'(prod_r);
        sq_res_r <= '0;
        sq_bit_r <= PW'(1) << (PW - 2);
      end
      S_MG_SQ: begin
        if (sq_bit_r != '0) begin
          if (sq_take) begin
            sq_v_r   <= sq_v_r - sq_trial;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end
      end
      S_MG_OUT: begin
        out_data_r <= '{bin_index: idx_r[5:0], magnitude: mag_sat, no_data: 1'b0,
                        last: (idx_r == last_bin)};
        idx_r <= idx_r + (KMAX + 1)'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> dv/tb_windowed_fft_magnitude_spectrum.sv
// ----------------------------------------------------------------------------
// tb_windowed_fft_magnitude_spectrum: self-checking bench for the spectrum block
// Streams samples and compute requests through the start/busy port. Every
// accepted request is run through an integer model of the windowed FFT, and
// each result strobe is checked against the oldest expected bin. Phases cover
// every window length, window kind and mean setting.
// ----------------------------------------------------------------------------
module tb_windowed_fft_magnitude_spectrum;
  import wfms_pkg::*;

  localparam int STORE_DEPTH = 128;
  localparam int NUM_PHASES  = 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_strobe;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [2:0] cfg_wdata;

  windowed_fft_magnitude_spectrum dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Model state.
  logic signed [15:0] hist [STORE_DEPTH];
  int unsigned        wr_ptr;
  int unsigned        fill;
  logic [2:0]         log2_len;
  logic [1:0]         win_sel;
  logic               mean_on;
  longint             wre [STORE_DEPTH];
  longint             wim [STORE_DEPTH];

  out_item_t bins_due [$];
  int        errors;
  int        n_results;
  int        n_computes;
  bit        allow_idle;

  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Q30 cosine and sine of 2*pi*num/den by truncating Horner series.
  task automatic cos_sin(input int unsigned num, input int unsigned den,
                         output longint c, output longint s);
    longint ck [5];
    longint sk [5];
    longint nn, q, r, x, x2, cx, t, sx;
    ck = '{90, 56, 30, 12, 2};
    sk = '{110, 72, 42, 20, 6};
    nn = longint'(num % den) * 4;
    q  = nn / den;
    r  = nn - q * den;
    x  = r * PI_HALF_Q30 / longint'(den);
    x2 = x * x / Q30_ONE;
    cx = Q30_ONE;
    t  = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      cx = Q30_ONE - (x2 * cx / Q30_ONE) / ck[i];
      t  = Q30_ONE - (x2 * t / Q30_ONE) / sk[i];
    end
    sx = x * t / Q30_ONE;
    case (q % 4)
      0:       begin c = cx;  s = sx;  end
      1:       begin c = -sx; s = cx;  end
      2:       begin c = -cx; s = -sx; end
      default: begin c = sx;  s = -cx; end
    endcase
  endtask

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  task automatic transform(input int unsigned n, input int k);
    int unsigned rev, half, stride, p;
    longint      c, s, tr, ti, ar, ai, br, bi, tmp;
    for (int unsigned i = 0; i < n; i++) begin
      rev = 0;
      for (int b = 0; b < k; b++) rev |= ((i >> b) & 1) << (k - 1 - b);
      if (rev > i) begin
        tmp = wre[i]; wre[i] = wre[rev]; wre[rev] = tmp;
        tmp = wim[i]; wim[i] = wim[rev]; wim[rev] = tmp;
      end
    end
    for (int unsigned len = 2; len <= n; len <<= 1) begin
      half   = len >> 1;
      stride = n / len;
      for (int unsigned j = 0; j < half; j++) begin
        cos_sin(j * stride, n, c, s);
        for (int unsigned i = j; i < n; i += len) begin
          p  = i + half;
          br = wre[p];
          bi = wim[p];
          tr = round_shift(br * c + bi * s, 30);
          ti = round_shift(bi * c - br * s, 30);
          ar = wre[i];
          ai = wim[i];
          wre[i] = ar + tr;
          wim[i] = ai + ti;
          wre[p] = ar - tr;
          wim[p] = ai - ti;
        end
      end
    end
  endtask

  // Updates the sample history and queues the bins one request produces.
  task automatic predict_spectrum(input in_item_t it);
    int          k;
    int unsigned n, base;
    longint      mean, sum, d, w, c, s, wq, re, im, m, mag;
    out_item_t   r;
    if (it.req_type == REQ_PUSH) begin
      hist[wr_ptr] = it.sample;
      wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
      if (fill < STORE_DEPTH) fill++;
      return;
    end
    n_computes++;
    k = (log2_len < 3) ? 3 : log2_len;
    n = 1 << k;
    if (fill < n) begin
      r = '{bin_index: 6'd0, magnitude: 16'd0, no_data: 1'b1, last: 1'b1};
      bins_due = {bins_due, r};
      return;
    end
    base = (wr_ptr + STORE_DEPTH - n) % STORE_DEPTH;
    mean = 0;
    if (mean_on) begin
      sum = 0;
      for (int unsigned i = 0; i < n; i++) sum += hist[(base + i) % STORE_DEPTH];
      mean = round_shift(sum, k);
    end
    for (int unsigned i = 0; i < n; i++) begin
      d = longint'(hist[(base + i) % STORE_DEPTH]) - mean;
      w = 32768;
      if (win_sel == WIN_HANN || win_sel == WIN_HAMMING) begin
        cos_sin(i, n - 1, c, s);
        if (win_sel == WIN_HANN) wq = (Q30_ONE - c) / 2;
        else                     wq = HAMMING_A - HAMMING_B * c / Q30_ONE;
        if (wq < 0)       wq = 0;
        if (wq > Q30_ONE) wq = Q30_ONE;
        w = round_shift(wq, 15);
      end
      wre[i] = round_shift(d * w, 15);
      wim[i] = 0;
    end
    transform(n, k);
    for (int unsigned i = 1; i < n / 2; i++) begin
      re  = (wre[i] < 0) ? -wre[i] : wre[i];
      im  = (wim[i] < 0) ? -wim[i] : wim[i];
      m   = int_sqrt(longint'(re * re + im * im));
      mag = floor_shift(m + (n >> 1), k);
      if (mag > 65535) mag = 65535;
      r.bin_index = i[5:0];
      r.magnitude = mag[15:0];
      r.no_data   = 1'b0;
      r.last      = (i == n / 2 - 1);
      bins_due = {bins_due, r};
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Results cannot be held off, so every strobe is checked at its edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      out_item_t e;
      n_results++;
      if (bins_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        e = bins_due.pop_front();
        if (out_data.bin_index !== e.bin_index)
          report_mismatch($sformatf("bin_index %0d, want %0d",
                                    out_data.bin_index, e.bin_index));
        if (out_data.magnitude !== e.magnitude)
          report_mismatch($sformatf("bin %0d magnitude %0d, want %0d",
                                    e.bin_index, out_data.magnitude, e.magnitude));
        if (out_data.no_data !== e.no_data)
          report_mismatch($sformatf("no_data %b, want %b", out_data.no_data, e.no_data));
        if (out_data.last !== e.last)
          report_mismatch($sformatf("bin %0d last %b, want %b",
                                    e.bin_index, out_data.last, e.last));
      end
    end
  end

  // Holds one item on the port until the block takes it.
  task automatic send_item(input in_item_t it);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_spectrum(it);
  endtask

  task automatic drain;
    int guard;
    start <= 1'b0;
    guard = 0;
    while (bins_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // A compute that gives no result could still be running.
    while (busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [2:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WINDOW_LOG2: log2_len = val;
      CFG_WINDOW_KIND: win_sel  = val[1:0];
      default:         mean_on  = val[0];
    endcase
  endtask

  function automatic in_item_t push_of(logic signed [15:0] v);
    in_item_t it;
    it.req_type = REQ_PUSH;
    it.sample   = v;
    return it;
  endfunction

  function automatic in_item_t compute_of(logic [15:0] junk);
    in_item_t it;
    it.req_type = REQ_COMPUTE;
    it.sample   = junk;
    return it;
  endfunction

  initial begin
    dir_row_t    rows [$];
    dir_row_t    row;
    out_item_t   got;
    logic [2:0]  ph_log2 [NUM_PHASES];
    logic [1:0]  ph_kind [NUM_PHASES];
    logic        ph_mean [NUM_PHASES];
    int          burst;
    in_item_t    it;

    start = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    rst_n = 1'b0;
    errors = 0; n_results = 0; n_computes = 0; allow_idle = 1'b1;
    wr_ptr = 0; fill = 0; log2_len = 3'd7; win_sel = WIN_RECT; mean_on = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) hist[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a compute straight after reset has no data at the reset length.
    row.item = compute_of(16'hFFFF); row.has_exp = 1;
    row.exp = '{bin_index: 6'd0, magnitude: 16'd0, no_data: 1'b1, last: 1'b1};
    rows = {rows, row};
    row.has_exp = 0;
    row.item = push_of(16'sh7FFF); rows = {rows, row};
    row.item = push_of(-16'sd32768); rows = {rows, row};
    row.item = push_of(16'sd0); rows = {rows, row};
    row.item = push_of(16'sh5555); rows = {rows, row};
    row.item = push_of(16'shAAAA); rows = {rows, row};
    row.item = push_of(16'sd1); rows = {rows, row};
    row.item = push_of(-16'sd1); rows = {rows, row};
    row.item = compute_of(16'h0000); row.has_exp = 1;   // still short at N = 128
    rows = {rows, row};
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].has_exp && bins_due.size() != 0) begin
        got = bins_due[bins_due.size() - 1];
        if (got !== rows[i].exp) report_mismatch("short-window prediction off");
      end
    end
    drain();

    // Short length, value below three acts as eight: one more push fills the eight-sample window.
    write_reg(CFG_WINDOW_LOG2, 3'd0);
    send_item(push_of(16'sh7FFF));
    send_item(compute_of(16'h1234));
    drain();

    ph_log2 = '{3'd3, 3'd7, 3'd4, 3'd5, 3'd6, 3'd3, 3'd4, 3'd7};
    ph_kind = '{WIN_HANN, WIN_HAMMING, 2'd3, WIN_RECT, WIN_HANN, WIN_HAMMING,
                WIN_RECT, WIN_HANN};
    ph_mean = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_WINDOW_LOG2, ph_log2[p]);
      write_reg(CFG_WINDOW_KIND, {1'b0, ph_kind[p]});
      write_reg(CFG_REMOVE_MEAN, {2'b0, ph_mean[p]});
      allow_idle = (p < NUM_PHASES - 2);
      // Two bursts of pushes, some at full scale, each followed by a compute.
      for (int r = 0; r < 2; r++) begin
        burst = $urandom_range(2, 8);
        for (int b = 0; b < burst; b++) begin
          it = push_of(16'($urandom));
          if ($urandom_range(0, 7) == 0) it.sample = $urandom_range(0, 1) ? 16'sh7FFF
                                                                          : -16'sd32768;
          send_item(it);
        end
        send_item(compute_of(16'($urandom)));
      end
      drain();
    end

    $display("%0d compute requests and %0d results checked over %0d settings",
             n_computes, n_results, NUM_PHASES + 2);
    if (errors == 0 && bins_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/wfms_pkg.sv
src/windowed_fft_magnitude_spectrum.sv
dv/tb_windowed_fft_magnitude_spectrum.sv
